/* rtl/alnnq_pkg.sv */
`default_nettype none

package alnnq_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W + 1;
  localparam int DIST_W     = SQ_W + 1;
  localparam int QUAD_W     = 3;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [QUAD_W-1:0] QUAD_LO_LO = 3'd0;
  localparam logic [QUAD_W-1:0] QUAD_LO_HI = 3'd1;
  localparam logic [QUAD_W-1:0] QUAD_HI_LO = 3'd2;
  localparam logic [QUAD_W-1:0] QUAD_HI_HI = 3'd3;
  localparam logic [QUAD_W-1:0] QUAD_NONE  = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic                      present;
    logic                      last_point;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  point_index;
    logic [IDX_W-1:0]  neighbor_index;
    logic              found;
    logic [QUAD_W-1:0] quadrant;
    logic              overflowed;
    logic              last_result;
  } out_t;

  // One command per accepted input transaction: an optional store and an optional run.
  typedef struct packed {
    logic                      wr;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      present;
    logic                      run;
    logic [CNT_W-1:0]          n;
    logic                      ovf;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      present;
  } pt_t;

endpackage

`default_nettype wire

/* rtl/alnnq_front.sv */
`default_nettype none

module alnnq_front
  import alnnq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic      in_full,
  input  wire in_t  in_data,
  input  wire logic q_full,
  output logic      q_push,
  output cmd_t      q_data
);

  logic [CNT_W-1:0] count_r;
  logic             ovf_r;
  logic             fits;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;
  assign fits    = (count_r < CNT_W'(MAX_POINTS));

  always_comb begin
    q_data         = '0;
    q_data.wr      = fits;
    q_data.idx     = count_r[IDX_W-1:0];
    q_data.x       = in_data.x_pos;
    q_data.y       = in_data.y_pos;
    q_data.present = in_data.present;
    q_data.run     = in_data.last_point;
    q_data.n       = fits ? count_r + CNT_W'(1) : count_r;
    q_data.ovf     = ovf_r || !fits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (q_push) begin
      if (in_data.last_point) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        count_r <= fits ? count_r + CNT_W'(1) : count_r;
        ovf_r   <= ovf_r || !fits;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/alnnq_cmdq.sv */
`default_nettype none

module alnnq_cmdq
  import alnnq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t wdata,
  output logic      full,
  input  wire logic pop,
  output cmd_t      rdata,
  output logic      empty
);

  cmd_t                  slot_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] count_r;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty   = (count_r == '0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + CMDQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CMDQ_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/alnnq_back.sv */
`default_nettype none

module alnnq_back
  import alnnq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire cmd_t q_data,
  output logic      q_pop,
  output logic      out_empty,
  input  wire logic out_pop,
  output out_t      out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t           state_r;
  pt_t              mem [MAX_POINTS];
  pt_t              rd_r;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] n_r;
  logic             ovf_r;
  logic [IDX_W-1:0] i_r;
  logic [IDX_W-1:0] j_r;
  pt_t              pi_r;

  // Scan pipeline: memory read, difference, square, then sum and compare.
  logic                      rd_v_r;
  logic [IDX_W-1:0]          rd_j_r;
  logic                      s1_v_r;
  logic                      s1_hit_r;
  logic [IDX_W-1:0]          s1_j_r;
  logic signed [COORD_W-1:0] s1_x_r;
  logic signed [COORD_W-1:0] s1_y_r;
  logic signed [DIFF_W-1:0]  dx_r;
  logic signed [DIFF_W-1:0]  dy_r;
  logic                      s2_v_r;
  logic                      s2_hit_r;
  logic [IDX_W-1:0]          s2_j_r;
  logic signed [COORD_W-1:0] s2_x_r;
  logic signed [COORD_W-1:0] s2_y_r;
  logic [SQ_W-1:0]           sqx_r;
  logic [SQ_W-1:0]           sqy_r;

  logic                      have_r;
  logic [DIST_W-1:0]         best_d_r;
  logic [IDX_W-1:0]          best_j_r;
  logic signed [COORD_W-1:0] best_x_r;
  logic signed [COORD_W-1:0] best_y_r;

  logic                      out_v_r;
  out_t                      out_r;

  logic signed [DIFF_W-1:0]   dx_c;
  logic signed [DIFF_W-1:0]   dy_c;
  logic signed [2*DIFF_W-1:0] prod_x;
  logic signed [2*DIFF_W-1:0] prod_y;
  logic [DIST_W-1:0]          dsum;
  logic                       better;
  logic                       scan_last;
  logic                       run_last;
  logic                       slot_free;
  logic [QUAD_W-1:0]          quad_c;
  out_t                       res_c;

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign rd_addr   = (state_r == ST_FETCH) ? i_r : j_r;
  assign dx_c      = DIFF_W'(pi_r.x) - DIFF_W'(rd_r.x);
  assign dy_c      = DIFF_W'(pi_r.y) - DIFF_W'(rd_r.y);
  assign prod_x    = dx_r * dx_r;
  assign prod_y    = dy_r * dy_r;
  assign dsum      = DIST_W'(sqx_r) + DIST_W'(sqy_r);
  assign better    = s2_v_r && s2_hit_r && (!have_r || dsum < best_d_r);
  assign scan_last = ({1'b0, j_r} == n_r - CNT_W'(1));
  assign run_last  = ({1'b0, i_r} == n_r - CNT_W'(1));
  assign slot_free = !out_v_r || out_pop;
  assign out_empty = !out_v_r;
  assign out_data  = out_r;

  always_comb begin
    if (pi_r.x == best_x_r || pi_r.y == best_y_r) begin
      quad_c = QUAD_NONE;
    end else if (pi_r.x < best_x_r) begin
      quad_c = (pi_r.y < best_y_r) ? QUAD_LO_LO : QUAD_LO_HI;
    end else begin
      quad_c = (pi_r.y < best_y_r) ? QUAD_HI_LO : QUAD_HI_HI;
    end
    res_c                = '0;
    res_c.point_index    = i_r;
    res_c.neighbor_index = have_r ? best_j_r : '0;
    res_c.found          = have_r;
    res_c.quadrant       = have_r ? quad_c : QUAD_NONE;
    res_c.overflowed     = ovf_r;
    res_c.last_result    = run_last;
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.wr) begin
      mem[q_data.idx] <= '{x: q_data.x, y: q_data.y, present: q_data.present};
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    s1_hit_r <= rd_v_r && rd_r.present && pi_r.present && (rd_j_r != i_r);
    s1_j_r   <= rd_j_r;
    s1_x_r   <= rd_r.x;
    s1_y_r   <= rd_r.y;
    dx_r     <= dx_c;
    dy_r     <= dy_c;
    s2_hit_r <= s1_hit_r;
    s2_j_r   <= s1_j_r;
    s2_x_r   <= s1_x_r;
    s2_y_r   <= s1_y_r;
    sqx_r    <= prod_x[SQ_W-1:0];
    sqy_r    <= prod_y[SQ_W-1:0];
    if (better) begin
      best_d_r <= dsum;
      best_j_r <= s2_j_r;
      best_x_r <= s2_x_r;
      best_y_r <= s2_y_r;
    end
    if (state_r == ST_LATCH) begin
      pi_r <= rd_r;
    end
    if (q_pop) begin
      n_r   <= q_data.n;
      ovf_r <= q_data.ovf;
    end
    if (state_r == ST_EMIT && slot_free) begin
      out_r <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      rd_v_r  <= 1'b0;
      rd_j_r  <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      have_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      rd_v_r <= (state_r == ST_SCAN);
      rd_j_r <= j_r;
      s1_v_r <= rd_v_r;
      s2_v_r <= s1_v_r;
      if (better) begin
        have_r <= 1'b1;
      end
      // In the emit state the output register is refilled below.
      if (out_pop && out_v_r && state_r != ST_EMIT) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_pop && q_data.run && q_data.n != '0) begin
            i_r     <= '0;
            state_r <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          have_r  <= 1'b0;
          state_r <= ST_LATCH;
        end
        ST_LATCH: begin
          j_r     <= '0;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          j_r <= j_r + IDX_W'(1);
          if (scan_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_v_r && !s1_v_r && !s2_v_r) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_v_r <= 1'b1;
            if (run_last) begin
              state_r <= ST_IDLE;
            end else begin
              i_r     <= i_r + IDX_W'(1);
              state_r <= ST_FETCH;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/all_nearest_neighbor_quadrant.sv */
// Loads up to 64 points, one per input transaction, and on the transaction marked last reports
// for every loaded point its nearest other present point (squared distance, lower index wins
// a tie) and the quadrant of that neighbor, one result per point in load order. Points load
// at one per cycle while the four-entry command queue has room; points past the 64th are
// dropped and flagged as overflowed. In a run each point is first fetched, then scans every
// stored point through the single read port of the point memory, one point per cycle, and
// then the distance pipeline drains before its result is emitted. Up to four input transactions
// queue up during a run and are taken once it finishes; further ones are held off by in_full.
`default_nettype none

module all_nearest_neighbor_quadrant
  import alnnq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic      in_full,
  input  wire in_t  in_data,
  output logic      out_empty,
  input  wire logic out_pop,
  output out_t      out_data
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;

  alnnq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  alnnq_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  alnnq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_none_quad : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.found) |-> (out_data.quadrant == QUAD_NONE))
    else $error("result without neighbor carries a quadrant");

  a_none_index : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.found) |-> (out_data.neighbor_index == '0))
    else $error("result without neighbor carries a neighbor index");

  a_not_self : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.found) |-> (out_data.neighbor_index != out_data.point_index))
    else $error("point reported as its own neighbor");

  a_next_index : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_data.last_result) |=>
      (out_empty || out_data.point_index == $past(out_data.point_index) + 6'd1))
    else $error("results out of load order");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import alnnq_pkg::*;

  localparam int STUCK_LIMIT = 40000;
  localparam int TARGET_ITEMS = 230;
  localparam int COORD_MIN = -8388608;
  localparam int COORD_MAX = 8388607;

  typedef struct packed {
    in_t  item;
    logic typed;
  } stim_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  in_t  in_data = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  out_t out_data;

  logic cur_typed = 1'b0;
  bit   idle_on = 1'b0;
  bit   moved;
  int   stuck_cycles = 0;
  int   errors = 0;
  int   sink_stall = 0;

  // Copy of the point set that is being loaded.
  logic signed [COORD_W-1:0] set_x [MAX_POINTS];
  logic signed [COORD_W-1:0] set_y [MAX_POINTS];
  logic                      set_on [MAX_POINTS];
  int                        set_len = 0;
  bit                        set_dropped = 1'b0;

  out_t  pending_results [$];
  out_t  typed_results [$];
  stim_t stim_q [$];

  all_nearest_neighbor_quadrant u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic out_t lit(int idx, int nb, bit fnd, logic [QUAD_W-1:0] q, bit lst);
    out_t r;
    r.point_index    = idx[IDX_W-1:0];
    r.neighbor_index = nb[IDX_W-1:0];
    r.found          = fnd;
    r.quadrant       = q;
    r.overflowed     = 1'b0;
    r.last_result    = lst;
    return r;
  endfunction

  task automatic add_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, bit p, bit l,
                           bit typed);
    stim_t s;
    s.item.x_pos      = x;
    s.item.y_pos      = y;
    s.item.present    = p;
    s.item.last_point = l;
    s.typed           = typed;
    stim_q.push_back(s);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord(int mode, logic [COORD_W-1:0] base);
    logic [COORD_W-1:0] c;
    case (mode)
      0: c = COORD_W'($urandom());
      1: c = COORD_W'($urandom_range(0, 8) - 4);
      2: begin
        case ($urandom_range(0, 3))
          0: c = COORD_MIN[COORD_W-1:0];
          1: c = COORD_MAX[COORD_W-1:0];
          2: c = '0;
          default: c = '1;
        endcase
      end
      default: c = base + COORD_W'($urandom_range(0, 64) - 32);
    endcase
    return c;
  endfunction

  // Stores one accepted point and, on the last one of a set, works out the whole run.
  task automatic take_point(in_t pt, logic typed);
    int      i, j, best;
    bit      have;
    longint  dx, dy, d, best_d;
    out_t    r;
    if (set_len < MAX_POINTS) begin
      set_x[set_len]  = pt.x_pos;
      set_y[set_len]  = pt.y_pos;
      set_on[set_len] = pt.present;
      set_len++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!pt.last_point) return;
    for (i = 0; i < set_len; i++) begin
      have = 1'b0;
      best = 0;
      best_d = 0;
      if (set_on[i]) begin
        for (j = 0; j < set_len; j++) begin
          if (j == i || !set_on[j]) continue;
          dx = longint'(set_x[i]) - longint'(set_x[j]);
          dy = longint'(set_y[i]) - longint'(set_y[j]);
          d = dx * dx + dy * dy;
          if (!have || d < best_d) begin
            have = 1'b1;
            best_d = d;
            best = j;
          end
        end
      end
      r.point_index    = i[IDX_W-1:0];
      r.neighbor_index = have ? best[IDX_W-1:0] : '0;
      r.found          = have;
      if (!have || set_x[i] == set_x[best] || set_y[i] == set_y[best]) begin
        r.quadrant = QUAD_NONE;
      end else if (set_x[i] < set_x[best]) begin
        r.quadrant = (set_y[i] < set_y[best]) ? QUAD_LO_LO : QUAD_LO_HI;
      end else begin
        r.quadrant = (set_y[i] < set_y[best]) ? QUAD_HI_LO : QUAD_HI_HI;
      end
      r.overflowed  = set_dropped;
      r.last_result = (i + 1 == set_len);
      if (typed) r = typed_results.pop_front();
      pending_results.push_back(r);
    end
    set_len = 0;
    set_dropped = 1'b0;
  endtask

  function automatic int field_bad(string name, logic [7:0] e, logic [7:0] a);
    if (e === a) return 0;
    $display("%0t: mismatch in %s, expected %0d, actual %0d", $time, name, e, a);
    return 1;
  endfunction

  task automatic check_result(out_t got);
    out_t e;
    int   bad;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result transaction, expected none, actual %p", $time, got);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    bad = field_bad("point_index", e.point_index, got.point_index)
        + field_bad("neighbor_index", e.neighbor_index, got.neighbor_index)
        + field_bad("found", e.found, got.found)
        + field_bad("quadrant", e.quadrant, got.quadrant)
        + field_bad("overflowed", e.overflowed, got.overflowed)
        + field_bad("last_result", e.last_result, got.last_result);
    if (bad != 0) errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (in_push && !in_full) begin
        take_point(in_data, cur_typed);
        moved = 1'b1;
      end
      if (out_pop && !out_empty) begin
        check_result(out_data);
        moved = 1'b1;
      end
      if (moved) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side: accepts whenever it can, apart from short random stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (sink_stall > 0) begin
      out_pop <= 1'b0;
      sink_stall--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_pop <= 1'b0;
      sink_stall = $urandom_range(1, 3) - 1;
    end else begin
      out_pop <= 1'b1;
    end
  end

  initial begin
    int    k, n, mode, len;
    bit    big_done;
    logic [COORD_W-1:0] bx, by;
    stim_t s;

    // Lone present point, then lone absent point: no neighbor either way.
    add_point(24'd300, -24'sd200, 1, 1, 1);
    typed_results.push_back(lit(0, 0, 0, QUAD_NONE, 1));
    add_point(24'd0, 24'd0, 0, 1, 1);
    typed_results.push_back(lit(0, 0, 0, QUAD_NONE, 1));
    // Opposite corners of the coordinate range.
    add_point(COORD_MIN[23:0], COORD_MIN[23:0], 1, 0, 1);
    add_point(COORD_MAX[23:0], COORD_MAX[23:0], 1, 1, 1);
    typed_results.push_back(lit(0, 1, 1, QUAD_LO_LO, 0));
    typed_results.push_back(lit(1, 0, 1, QUAD_HI_HI, 1));
    add_point(COORD_MIN[23:0], COORD_MAX[23:0], 1, 0, 1);
    add_point(COORD_MAX[23:0], COORD_MIN[23:0], 1, 1, 1);
    typed_results.push_back(lit(0, 1, 1, QUAD_LO_HI, 0));
    typed_results.push_back(lit(1, 0, 1, QUAD_HI_LO, 1));
    // Shared x coordinate: neighbor found but no quadrant hint.
    add_point(24'd0, 24'd0, 1, 0, 1);
    add_point(24'd0, 24'd5, 1, 1, 1);
    typed_results.push_back(lit(0, 1, 1, QUAD_NONE, 0));
    typed_results.push_back(lit(1, 0, 1, QUAD_NONE, 1));
    // Equal distances from the first point: the lower index wins.
    add_point(24'd0, 24'd0, 1, 0, 1);
    add_point(24'd10, 24'd10, 1, 0, 1);
    add_point(-24'sd10, -24'sd10, 1, 1, 1);
    typed_results.push_back(lit(0, 1, 1, QUAD_LO_LO, 0));
    typed_results.push_back(lit(1, 0, 1, QUAD_HI_HI, 0));
    typed_results.push_back(lit(2, 0, 1, QUAD_LO_LO, 1));
    // Absent points mixed into sets.
    add_point(24'd5, 24'd5, 1, 0, 0);
    add_point(24'd6, 24'd6, 0, 0, 0);
    add_point(24'd100, -24'sd100, 1, 1, 0);
    add_point(-24'sd1, 24'd1, 1, 0, 0);
    add_point(24'd1, -24'sd1, 1, 1, 0);
    add_point(24'd7, 24'd7, 0, 0, 0);
    add_point(24'd8, 24'd8, 1, 0, 0);
    add_point(24'd9, 24'd9, 0, 1, 0);

    // Random sets, mostly small, with one set that fills the store and spills over.
    big_done = 1'b0;
    while (stim_q.size() < TARGET_ITEMS) begin
      if (!big_done && stim_q.size() > 80) begin
        big_done = 1'b1;
        len = MAX_POINTS + $urandom_range(1, 3);
        mode = 0;
      end else begin
        len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 8);
        mode = $urandom_range(0, 3);
      end
      bx = COORD_W'($urandom());
      by = COORD_W'($urandom());
      for (k = 0; k < len; k++) begin
        add_point(rand_coord(mode, bx), rand_coord(mode, by), $urandom_range(0, 7) != 0,
                  k == len - 1, 0);
      end
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    n = 0;
    foreach (stim_q[i]) begin
      s = stim_q[i];
      if (i == 0 || stim_q[i-1].item.last_point) begin
        idle_on = (i < stim_q.size() * 85 / 100) && ($urandom_range(0, 3) != 0);
      end
      if (idle_on && $urandom_range(0, 3) == 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      in_push   <= 1'b1;
      in_data   <= s.item;
      cur_typed <= s.typed;
      @(posedge clk);
      while (in_full) @(posedge clk);
      @(negedge clk);
      n++;
    end
    in_push <= 1'b0;
    idle_on = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/alnnq_pkg.sv
rtl/alnnq_front.sv
rtl/alnnq_cmdq.sv
rtl/alnnq_back.sv
rtl/all_nearest_neighbor_quadrant.sv
sim/tb.sv
